FILE: rtl/core/smx_pkg.sv
// smx_pkg: shared types and constants for the softmax vector block.
// Used by the interfaces, controller, datapath and top level.
`default_nettype none
package smx_pkg;
   localparam int MaxLen  = 64;
   localparam int AddrW   = $clog2(MaxLen);
   localparam int CountW  = AddrW + 1;

   typedef struct packed {
      logic signed [15:0] logit;
      logic               is_last;
   } req_type;

   typedef struct packed {
      logic [15:0] probability;
      logic        final_out;
      logic        overflowed;
   } rsp_type;

   // Datapath commands from the controller.
   typedef struct packed {
      logic             load;       // store one element
      logic             rd;         // read store entry at addr
      logic [AddrW-1:0] addr;
      logic             exp_start;  // start exponential on read data
      logic             acc;        // add exponential result to sum
      logic             div_start;  // start reciprocal
      logic             out_load;   // not set by the controller, not read by the datapath
      logic             clear;      // end of vector
   } cmd_type;

   typedef struct packed {
      logic exp_done;
      logic div_done;
   } sts_type;

   function automatic logic [15:0] int_exp(input logic [3:0] i);
      logic [15:0] v;
      unique case (i)
         4'd0:  v = 16'hFFFF; // 65536 substituted by the caller
         4'd1:  v = 16'd24109;
         4'd2:  v = 16'd8869;
         4'd3:  v = 16'd3263;
         4'd4:  v = 16'd1200;
         4'd5:  v = 16'd442;
         4'd6:  v = 16'd162;
         4'd7:  v = 16'd60;
         4'd8:  v = 16'd22;
         4'd9:  v = 16'd8;
         4'd10: v = 16'd3;
         4'd11: v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic [15:0] frac_exp(input logic [3:0] k);
      logic [15:0] v;
      unique case (k)
         4'd0:  v = 16'd65520;
         4'd1:  v = 16'd65504;
         4'd2:  v = 16'd65472;
         4'd3:  v = 16'd65408;
         4'd4:  v = 16'd65280;
         4'd5:  v = 16'd65026;
         4'd6:  v = 16'd64520;
         4'd7:  v = 16'd63520;
         4'd8:  v = 16'd61565;
         4'd9:  v = 16'd57835;
         4'd10: v = 16'd51039;
         4'd11: v = 16'd39750;
         default: v = 16'd65535;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/core/smx_req_if.sv
// smx_req_if / smx_rsp_if: valid-ready channels of the softmax block.
// Depends on smx_pkg for the payload types.
`default_nettype none
interface smx_req_if;
   import smx_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface smx_rsp_if;
   import smx_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/smx_datapath.sv
// smx_datapath: element store, maximum, iterative exponential, sum, reciprocal
// divider and output multiply. Depends on smx_pkg.
`default_nettype none
module smx_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire smx_pkg::cmd_type        cmd,
   input  wire logic signed [15:0]      in_logit,
   output smx_pkg::sts_type             sts,
   output logic [15:0]                  prob
);
   import smx_pkg::*;

   logic signed [15:0] mem [MaxLen];
   logic signed [15:0] rd_ff;
   logic signed [15:0] max_ff, max_in;
   logic [16:0] v_ff, v_in;       // Q0.16 with room for 1.0
   logic [11:0] frac_ff, frac_in;
   logic [3:0]  k_ff, k_in;
   logic        exp_busy_ff, exp_busy_in;
   logic [22:0] sum_ff, sum_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] quo_ff, quo_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic        div_busy_ff, div_busy_in;
   logic [33:0] prod_ff;
   logic [16:0] d;
   logic [32:0] mul;
   logic [33:0] trial;
   logic [23:0] divisor;

   always_ff @(posedge clock) begin
      if (cmd.load) mem[cmd.addr] <= in_logit;
      if (cmd.rd) rd_ff <= mem[cmd.addr];
   end

   assign d   = {1'b0, max_ff} - {rd_ff[15], rd_ff};
   assign mul = v_ff * frac_exp(k_ff);
   assign divisor = (sum_ff == '0) ? 24'd1 : {1'b0, sum_ff};
   assign trial = {rem_ff, quo_ff[32]} - {10'd0, divisor};

   always_comb begin
      max_in = max_ff;
      if (cmd.clear) max_in = 16'sh8000;
      else if (cmd.load && in_logit > max_ff) max_in = in_logit;

      v_in = v_ff; frac_in = frac_ff; k_in = k_ff; exp_busy_in = exp_busy_ff;
      if (cmd.exp_start) begin
         v_in = (d[15:12] == 4'd0) ? 17'h10000 : {1'b0, int_exp(d[15:12])};
         frac_in = d[11:0];
         k_in = 4'd11;
         exp_busy_in = 1'b1;
      end else if (exp_busy_ff) begin
         // one fraction bit per cycle, high bit first
         if (frac_ff[k_ff]) v_in = 17'((mul + 33'd32768) >> 16);
         if (k_ff == 4'd0) exp_busy_in = 1'b0;
         else k_in = k_ff - 4'd1;
      end

      sum_in = sum_ff;
      if (cmd.clear) sum_in = '0;
      else if (cmd.acc) sum_in = sum_ff + 23'(v_ff);

      rem_in = rem_ff; quo_in = quo_ff; dcnt_in = dcnt_ff; div_busy_in = div_busy_ff;
      if (cmd.div_start) begin
         rem_in = '0;
         quo_in = 33'h1_0000_0000 + 33'(divisor >> 1);
         dcnt_in = 6'd32;
         div_busy_in = 1'b1;
      end else if (div_busy_ff) begin
         // restoring division, one quotient bit per cycle
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[32]};
            quo_in = {quo_ff[31:0], 1'b0};
         end
         if (dcnt_ff == 6'd0) div_busy_in = 1'b0;
         else dcnt_in = dcnt_ff - 6'd1;
      end
   end

   // Reciprocal is at most 2^32; v*r fits 34 bits since v never exceeds the sum.
   always_ff @(posedge clock) begin
      prod_ff <= 34'(v_ff) * 34'(quo_ff[16:0])
               + 34'(v_ff) * {1'b0, quo_ff[32:17], 17'd0};
   end

   always_comb begin
      logic [33:0] p;
      p = (prod_ff + 34'd32768) >> 16;
      prob = (p > 34'd65535) ? 16'hFFFF : p[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= 16'sh8000;
         exp_busy_ff <= 1'b0;
         sum_ff <= '0;
         div_busy_ff <= 1'b0;
      end else begin
         max_ff <= max_in;
         exp_busy_ff <= exp_busy_in;
         sum_ff <= sum_in;
         div_busy_ff <= div_busy_in;
      end
      v_ff <= v_in; frac_ff <= frac_in; k_ff <= k_in;
      rem_ff <= rem_in; quo_ff <= quo_in; dcnt_ff <= dcnt_in;
   end

   assign sts.exp_done = !exp_busy_ff;
   assign sts.div_done = !div_busy_ff;
endmodule
`default_nettype wire

FILE: rtl/core/smx_control.sv
// smx_control: sequencer for loading, summing, reciprocal and output passes.
// Depends on smx_pkg; drives smx_datapath through cmd_type.
`default_nettype none
module smx_control (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_is_last,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_final,
   output logic                    rsp_ovf,
   output smx_pkg::cmd_type        cmd,
   input  wire smx_pkg::sts_type   sts
);
   import smx_pkg::*;

   typedef enum logic [3:0] {
      S_LOAD, S_SRD, S_SEXP, S_SWAIT, S_SACC, S_DIV, S_DWAIT,
      S_ORD, S_OEXP, S_OWAIT, S_OMUL, S_OFORM, S_OSEND
   } state_type;

   state_type         state_ff;
   logic [CountW-1:0] count_ff;
   logic [AddrW-1:0]  idx_ff;
   logic              drop_ff;
   logic              rsp_valid_ff;
   logic              final_ff;
   logic              take;

   assign req_ready = (state_ff == S_LOAD);
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_final = final_ff;
   assign rsp_ovf   = drop_ff;

   always_comb begin
      cmd = '0;
      cmd.addr = (state_ff == S_LOAD) ? count_ff[AddrW-1:0] : idx_ff;
      cmd.load = take && (count_ff < CountW'(MaxLen));
      cmd.rd = (state_ff == S_SRD) || (state_ff == S_ORD);
      cmd.exp_start = (state_ff == S_SEXP) || (state_ff == S_OEXP);
      cmd.acc = (state_ff == S_SACC);
      cmd.div_start = (state_ff == S_DIV);
      cmd.clear = (state_ff == S_OSEND) && rsp_ready && final_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         idx_ff <= '0;
         drop_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD: if (take) begin
               if (count_ff < CountW'(MaxLen)) count_ff <= count_ff + 1'b1;
               else drop_ff <= 1'b1;
               idx_ff <= '0;
               if (req_is_last) state_ff <= S_SRD;
            end
            S_SRD:  state_ff <= S_SEXP;
            S_SEXP: state_ff <= S_SWAIT;
            S_SWAIT: if (sts.exp_done) state_ff <= S_SACC;
            S_SACC: begin
               if (CountW'(idx_ff) + 1'b1 == count_ff) begin
                  idx_ff <= '0;
                  state_ff <= S_DIV;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_SRD;
               end
            end
            S_DIV:   state_ff <= S_DWAIT;
            S_DWAIT: if (sts.div_done) state_ff <= S_ORD;
            S_ORD:   state_ff <= S_OEXP;
            S_OEXP:  state_ff <= S_OWAIT;
            S_OWAIT: if (sts.exp_done) state_ff <= S_OMUL;
            S_OMUL:  state_ff <= S_OFORM;
            S_OFORM: begin
               rsp_valid_ff <= 1'b1;
               final_ff <= (CountW'(idx_ff) + 1'b1 == count_ff);
               state_ff <= S_OSEND;
            end
            S_OSEND: if (rsp_ready) begin
               rsp_valid_ff <= 1'b0;
               if (final_ff) begin
                  count_ff <= '0;
                  drop_ff <= 1'b0;
                  final_ff <= 1'b0;
                  state_ff <= S_LOAD;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_ORD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/softmax_vector.sv
// softmax_vector: top level of the softmax block.
// Depends on smx_pkg, smx_req_if, smx_rsp_if, smx_control and smx_datapath.
//
// Usage: logits (signed Q4.12) arrive one per transfer on the req channel;
// the transfer with is_last set closes the vector. Up to 64 elements are
// kept; later ones are dropped and every result of that vector carries
// overflowed. Loading takes one cycle per element.
// After the closing transfer the block makes two passes over the store:
// a summing pass (one exponential fraction bit per cycle in a shared
// iterative unit), a bit-serial reciprocal, then an output pass.
// Probabilities (unsigned Q0.16) leave on the rsp channel in input order,
// final_out marking the last. Input is not accepted until the whole vector
// has been sent. When the receiver stalls the result is held in its output
// register and the sequencer waits. Synchronous reset returns the block to
// the loading state with an empty vector; the store itself is not cleared.
`default_nettype none
module softmax_vector (
   input wire logic clock,
   input wire logic reset,
   smx_req_if.sink  req,
   smx_rsp_if.source rsp
);
   import smx_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [15:0] prob;
   logic [15:0] prob_ff;
   logic        out_take;
   logic        rsp_final;
   logic        rsp_ovf;

   smx_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_is_last(req.data.is_last),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_final(rsp_final), .rsp_ovf(rsp_ovf),
      .cmd(cmd), .sts(sts)
   );

   smx_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .in_logit(req.data.logit),
      .sts(sts), .prob(prob)
   );

   // Capture the probability when the controller raises the result.
   assign out_take = rsp.valid;
   always_ff @(posedge clock) begin
      if (!out_take) prob_ff <= prob;
   end
   assign rsp.data = '{probability: prob_ff, final_out: rsp_final, overflowed: rsp_ovf};
endmodule
`default_nettype wire

FILE: bench/smx_bench_if.sv
// smx_bench_if: holds smx_bench_pkg (IdleMax) for the bench; the channel interfaces come from the RTL.
// Depends on smx_pkg only; smx_req_if and smx_rsp_if are in rtl/core/smx_req_if.sv.
package smx_bench_pkg;
   import smx_pkg::*;
   localparam int IdleMax = 19;
endpackage

FILE: bench/smx_checker.sv
// smx_checker: watches the request and result channels of softmax_vector,
// predicts every probability of each closed vector and compares in order.
// Depends on smx_pkg and the channel interfaces.
module smx_checker
   import smx_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   smx_req_if       req,
   smx_rsp_if       rsp,
   output int       fail_count,
   output int       pending_count
);
   logic signed [15:0] logits [MaxLen];
   int                 n_loaded;
   logic signed [15:0] vec_max;
   logic               dropped;
   rsp_type            expected_q [$];

   // exp(-d) in Q0.16, d unsigned Q4.12.
   function automatic longint unsigned neg_exp(input logic [15:0] d);
      longint unsigned v;
      case (d[15:12])
         4'd0:  v = 65536;
         4'd1:  v = 24109;
         4'd2:  v = 8869;
         4'd3:  v = 3263;
         4'd4:  v = 1200;
         4'd5:  v = 442;
         4'd6:  v = 162;
         4'd7:  v = 60;
         4'd8:  v = 22;
         4'd9:  v = 8;
         4'd10: v = 3;
         4'd11: v = 1;
         default: v = 0;
      endcase
      for (int k = 11; k >= 0; k--) begin
         if (d[k]) begin
            case (k)
               0:  v = v * 65520;
               1:  v = v * 65504;
               2:  v = v * 65472;
               3:  v = v * 65408;
               4:  v = v * 65280;
               5:  v = v * 65026;
               6:  v = v * 64520;
               7:  v = v * 63520;
               8:  v = v * 61565;
               9:  v = v * 57835;
               10: v = v * 51039;
               default: v = v * 39750;
            endcase
            v = (v + 32768) >> 16;
         end
      end
      return v;
   endfunction

   task automatic close_vector();
      longint unsigned total, recip, p;
      logic [15:0]     diff;
      rsp_type         r;
      total = 0;
      for (int i = 0; i < n_loaded; i++) begin
         diff = vec_max - logits[i];
         total += neg_exp(diff);
      end
      total &= 64'h7F_FFFF;
      if (total == 0) total = 1;
      recip = ((64'd1 << 32) + (total >> 1)) / total;
      for (int i = 0; i < n_loaded; i++) begin
         diff = vec_max - logits[i];
         p = (neg_exp(diff) * recip + 32768) >> 16;
         r.probability = (p > 65535) ? 16'hFFFF : p[15:0];
         r.final_out   = (i + 1 == n_loaded);
         r.overflowed  = dropped;
         expected_q.push_back(r);
      end
      n_loaded = 0;
      vec_max  = -16'sd32768;
      dropped  = 1'b0;
   endtask

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         n_loaded   = 0;
         vec_max    = -16'sd32768;
         dropped    = 1'b0;
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %p", $time, rsp.data);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (exp_r !== rsp.data) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, rsp.data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req.valid && req.ready) begin
            // State is updated by blocking writes so close_vector sees it at once.
            if (n_loaded < MaxLen) begin
               logits[n_loaded] = req.data.logit;
               n_loaded = n_loaded + 1;
               if (req.data.logit > vec_max) vec_max = req.data.logit;
            end else begin
               dropped = 1'b1;
            end
            if (req.data.is_last && n_loaded > 0) close_vector();
         end
      end
   end
endmodule

FILE: bench/tb_top.sv
// tb_top: drives vectors of logits into softmax_vector and gives the verdict.
// Depends on smx_pkg, smx_bench_pkg, the channel interfaces, smx_checker and the RTL.
module tb_top;
   import smx_pkg::*;
   import smx_bench_pkg::*;
   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, quiet_cycles;
   int   rsp_wait;
   bit   hold_off = 1'b0;
   bit   sending_done = 1'b0;
   smx_req_if req ();
   smx_rsp_if rsp ();

   softmax_vector u_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));
   smx_checker u_chk (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                      .fail_count(fail_count), .pending_count(pending_count));

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.data  = '0;
      rsp.ready = 1'b0;
   end

   task automatic send_logit(input logic signed [15:0] x, input logic last);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, IdleMax);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= '{logit: x, is_last: last};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_logit(input int spread);
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom_range(0, 65535) >> spread);
      endcase
   endfunction

   task automatic send_vector(input int len, input int spread);
      for (int i = 0; i < len; i++) send_logit(rand_logit(spread), i == len - 1);
   endtask

   // Receiver: a random wait before each transfer, plus one long hold-off.
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_wait  <= 0;
      end else if (hold_off) begin
         rsp.ready <= 1'b0;
      end else if (rsp.valid && rsp.ready) begin
         gap = $urandom_range(0, IdleMax);
         rsp_wait  <= gap;
         rsp.ready <= (gap == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp.ready <= (rsp_wait == 1);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int tail;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: single elements at both extremes, ties, wide spread.
      send_logit(16'sh7FFF, 1'b1);
      send_logit(-16'sh8000, 1'b1);
      send_logit(16'sh0000, 1'b0);
      send_logit(16'sh0000, 1'b1);
      send_logit(16'sh7FFF, 1'b0);
      send_logit(-16'sh8000, 1'b0);
      send_logit(16'sh0FFF, 1'b0);
      send_logit(16'sh1000, 1'b1);
      send_logit(16'sh5555, 1'b0);
      send_logit(-16'sh2AAB, 1'b1);
      // Overflow: 66 elements, last two are dropped, the last closing the vector.
      for (int i = 0; i < 66; i++) send_logit(16'(i * 97), i == 65);
      // Long receiver hold-off while the sender keeps offering.
      fork
         begin
            hold_off = 1'b1;
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            send_vector(8, 2);
            send_vector(3, 4);
         end
      join
      for (int v = 0; v < 5; v++) begin
         send_vector($urandom_range(0, 7) == 0 ? $urandom_range(1, 70) : $urandom_range(1, 6),
                     $urandom_range(0, 4));
      end
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      tail = 0;
      while (tail < 200) begin
         @(posedge clock);
         tail++;
      end
      if (fail_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
